>>> rtl/i2cra_pkg.sv
// i2cra_pkg: shared types and constants for the i2c register access master
// bus phase codes, request kinds, transfer field layouts
// no dependencies
package i2cra_pkg;

   // request kinds carried on req_tuser
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   // acknowledge timeout after reset
   localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

   // last bit index of a byte
   localparam logic [2:0] BIT_LAST = 3'd7;

   // half-bit bus phases, one-hot
   typedef enum logic [27:0] {
      PH_IDLE    = 28'h0000001,
      PH_S_HI    = 28'h0000002,
      PH_S_FALL  = 28'h0000004,
      PH_A_LO    = 28'h0000008,
      PH_A_HI    = 28'h0000010,
      PH_AK1_LO  = 28'h0000020,
      PH_AK1_HI  = 28'h0000040,
      PH_R_LO    = 28'h0000080,
      PH_R_HI    = 28'h0000100,
      PH_AK2_LO  = 28'h0000200,
      PH_AK2_HI  = 28'h0000400,
      PH_D_LO    = 28'h0000800,
      PH_D_HI    = 28'h0001000,
      PH_AK3_LO  = 28'h0002000,
      PH_AK3_HI  = 28'h0004000,
      PH_RS_LO   = 28'h0008000,
      PH_RS_HI   = 28'h0010000,
      PH_RS_FALL = 28'h0020000,
      PH_AR_LO   = 28'h0040000,
      PH_AR_HI   = 28'h0080000,
      PH_AK4_LO  = 28'h0100000,
      PH_AK4_HI  = 28'h0200000,
      PH_IN_LO   = 28'h0400000,
      PH_IN_HI   = 28'h0800000,
      PH_MA_LO   = 28'h1000000,
      PH_MA_HI   = 28'h2000000,
      PH_P_LO    = 28'h4000000,
      PH_P_HI    = 28'h8000000
   } phase_type;

   // input item, request kind kept apart
   typedef struct packed {
      logic       sda_sample;
      logic       ack_after_read;
      logic [7:0] write_data;
      logic [7:0] register_address;
      logic [6:0] device_address;
   } req_data_type;

   // result item, scl_level in the lowest bit
   typedef struct packed {
      logic       ack_error;
      logic [7:0] read_data;
      logic       done_res;
      logic       busy_res;
      logic       sda_output_enable;
      logic       sda_level;
      logic       scl_level;
   } rsp_data_type;

endpackage

>>> rtl/i2cra_seq.sv
// i2cra_seq: half-bit bus sequencer, at most one phase step per accepted tick
// holds transaction state and forms the result of each transfer
// depends on i2cra_pkg
module i2cra_seq
   import i2cra_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         item_accept,
   input  logic [1:0]   item_kind,
   input  req_data_type item_data,
   input  logic [7:0]   ack_timeout,
   output rsp_data_type result
);

   phase_type  phase_ff, phase_in;
   logic [2:0] bit_cnt_ff, bit_cnt_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] wait_cnt_ff, wait_cnt_in;
   logic [6:0] held_dev_ff, held_dev_in;
   logic [7:0] held_reg_ff, held_reg_in;
   logic [7:0] held_wdata_ff, held_wdata_in;
   logic       held_rd_ff, held_rd_in;
   logic       held_ack_ff, held_ack_in;
   logic [7:0] rx_byte_ff, rx_byte_in;
   logic       err_ff, err_in;
   logic       done;
   logic [8:0] waited;

   assign waited = {1'b0, wait_cnt_ff} + 9'd1;

   // next state for one transfer
   always_comb begin
      phase_in      = phase_ff;
      bit_cnt_in    = bit_cnt_ff;
      shift_in      = shift_ff;
      wait_cnt_in   = wait_cnt_ff;
      held_dev_in   = held_dev_ff;
      held_reg_in   = held_reg_ff;
      held_wdata_in = held_wdata_ff;
      held_rd_in    = held_rd_ff;
      held_ack_in   = held_ack_ff;
      rx_byte_in    = rx_byte_ff;
      err_in        = err_ff;
      done          = 1'b0;
      if (item_accept) begin
         if (item_kind == REQ_TICK) begin
            case (phase_ff)
               PH_S_HI:   phase_in = PH_S_FALL;
               PH_RS_LO:  phase_in = PH_RS_HI;
               PH_RS_HI:  phase_in = PH_RS_FALL;
               PH_A_LO:   phase_in = PH_A_HI;
               PH_R_LO:   phase_in = PH_R_HI;
               PH_D_LO:   phase_in = PH_D_HI;
               PH_AR_LO:  phase_in = PH_AR_HI;
               PH_AK1_LO: phase_in = PH_AK1_HI;
               PH_AK2_LO: phase_in = PH_AK2_HI;
               PH_AK3_LO: phase_in = PH_AK3_HI;
               PH_AK4_LO: phase_in = PH_AK4_HI;
               PH_IN_LO:  phase_in = PH_IN_HI;
               PH_MA_LO:  phase_in = PH_MA_HI;
               PH_MA_HI:  phase_in = PH_P_LO;
               PH_P_LO:   phase_in = PH_P_HI;
               PH_S_FALL: begin
                  shift_in   = {held_dev_ff, 1'b0};
                  bit_cnt_in = '0;
                  phase_in   = PH_A_LO;
               end
               PH_RS_FALL: begin
                  shift_in   = {held_dev_ff, 1'b1};
                  bit_cnt_in = '0;
                  phase_in   = PH_AR_LO;
               end
               // address, register and data bits out
               PH_A_HI, PH_R_HI, PH_D_HI, PH_AR_HI: begin
                  shift_in = {shift_ff[6:0], 1'b0};
                  if (bit_cnt_ff == BIT_LAST) begin
                     bit_cnt_in  = '0;
                     wait_cnt_in = '0;
                     case (phase_ff)
                        PH_A_HI: phase_in = PH_AK1_LO;
                        PH_R_HI: phase_in = PH_AK2_LO;
                        PH_D_HI: phase_in = PH_AK3_LO;
                        default: phase_in = PH_AK4_LO;
                     endcase
                  end else begin
                     bit_cnt_in = bit_cnt_ff + 3'd1;
                     case (phase_ff)
                        PH_A_HI: phase_in = PH_A_LO;
                        PH_R_HI: phase_in = PH_R_LO;
                        PH_D_HI: phase_in = PH_D_LO;
                        default: phase_in = PH_AR_LO;
                     endcase
                  end
               end
               // acknowledge slots with timeout
               PH_AK1_HI, PH_AK2_HI, PH_AK3_HI, PH_AK4_HI: begin
                  if (item_data.sda_sample) begin
                     if (waited > {1'b0, ack_timeout}) begin
                        err_in   = 1'b1;
                        phase_in = PH_P_LO;
                     end else begin
                        wait_cnt_in = waited[7:0];
                     end
                  end else begin
                     case (phase_ff)
                        PH_AK1_HI: begin
                           shift_in   = held_reg_ff;
                           bit_cnt_in = '0;
                           phase_in   = PH_R_LO;
                        end
                        PH_AK2_HI: begin
                           if (held_rd_ff) begin
                              phase_in = PH_RS_LO;
                           end else begin
                              shift_in   = held_wdata_ff;
                              bit_cnt_in = '0;
                              phase_in   = PH_D_LO;
                           end
                        end
                        PH_AK3_HI: phase_in = PH_P_LO;
                        default: begin
                           shift_in   = '0;
                           bit_cnt_in = '0;
                           phase_in   = PH_IN_LO;
                        end
                     endcase
                  end
               end
               // read byte in, msb first
               PH_IN_HI: begin
                  shift_in = {shift_ff[6:0], item_data.sda_sample};
                  if (bit_cnt_ff == BIT_LAST) begin
                     bit_cnt_in = '0;
                     rx_byte_in = {shift_ff[6:0], item_data.sda_sample};
                     phase_in   = PH_MA_LO;
                  end else begin
                     bit_cnt_in = bit_cnt_ff + 3'd1;
                     phase_in   = PH_IN_LO;
                  end
               end
               PH_P_HI: begin
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end
               default: phase_in = PH_IDLE;
            endcase
         end else if ((item_kind inside {REQ_WRITE, REQ_READ}) && phase_ff == PH_IDLE) begin
            held_dev_in   = item_data.device_address;
            held_reg_in   = item_data.register_address;
            held_wdata_in = item_data.write_data;
            held_ack_in   = item_data.ack_after_read;
            held_rd_in    = (item_kind == REQ_READ);
            err_in        = 1'b0;
            bit_cnt_in    = '0;
            wait_cnt_in   = '0;
            phase_in      = PH_S_HI;
         end
      end
   end

   // line levels for the new phase
   always_comb begin
      result.scl_level         = 1'b1;
      result.sda_level         = 1'b1;
      result.sda_output_enable = 1'b1;
      case (phase_in)
         PH_S_FALL, PH_RS_FALL: result.sda_level = 1'b0;
         PH_RS_LO:              result.scl_level = 1'b0;
         PH_A_LO, PH_R_LO, PH_D_LO, PH_AR_LO: begin
            result.scl_level = 1'b0;
            result.sda_level = shift_in[7];
         end
         PH_A_HI, PH_R_HI, PH_D_HI, PH_AR_HI: result.sda_level = shift_in[7];
         PH_AK1_LO, PH_AK2_LO, PH_AK3_LO, PH_AK4_LO, PH_IN_LO: begin
            result.scl_level         = 1'b0;
            result.sda_output_enable = 1'b0;
         end
         PH_AK1_HI, PH_AK2_HI, PH_AK3_HI, PH_AK4_HI, PH_IN_HI:
            result.sda_output_enable = 1'b0;
         PH_MA_LO: begin
            result.scl_level = 1'b0;
            result.sda_level = ~held_ack_in;
         end
         PH_MA_HI: result.sda_level = ~held_ack_in;
         PH_P_LO: begin
            result.scl_level = 1'b0;
            result.sda_level = 1'b0;
         end
         PH_P_HI: result.sda_level = 1'b0;
         default: ;
      endcase
      result.busy_res  = (phase_in != PH_IDLE);
      result.done_res  = done;
      result.read_data = rx_byte_in;
      result.ack_error = err_in;
   end

   // transaction state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_cnt_ff    <= '0;
         shift_ff      <= '0;
         wait_cnt_ff   <= '0;
         held_dev_ff   <= '0;
         held_reg_ff   <= '0;
         held_wdata_ff <= '0;
         held_rd_ff    <= 1'b0;
         held_ack_ff   <= 1'b0;
         rx_byte_ff    <= '0;
         err_ff        <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         bit_cnt_ff    <= bit_cnt_in;
         shift_ff      <= shift_in;
         wait_cnt_ff   <= wait_cnt_in;
         held_dev_ff   <= held_dev_in;
         held_reg_ff   <= held_reg_in;
         held_wdata_ff <= held_wdata_in;
         held_rd_ff    <= held_rd_in;
         held_ack_ff   <= held_ack_in;
         rx_byte_ff    <= rx_byte_in;
         err_ff        <= err_in;
      end
   end

endmodule

>>> rtl/i2c_register_access_master_core.sv
// The result of a transfer is registered and shows in the cycle after acceptance.
// Throughput: one transfer per cycle unless the req side stalls; each tick steps at most
// one half-bit phase in the sequencer. The req side stalls only while a held result waits
// on rsp_tready. Reset (synchronous, active high): bus idle with both lines high,
// other sequencer state zero, ack timeout 250, result register empty.
// depends on i2cra_pkg and i2cra_seq
module i2c_register_access_master_core
   import i2cra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // device_address[6:0], register_address[14:7], write_data[22:15],
   // ack_after_read[23], sda_sample[24], zero fill[31:25]
   input  logic [31:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // scl_level[0], sda_level[1], sda_output_enable[2], busy_res[3],
   // done_res[4], read_data[12:5], ack_error[13], zero fill[15:14]
   output logic [15:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   logic         rsp_valid_ff;
   rsp_data_type rsp_data_ff;
   logic [7:0]   timeout_ff;
   logic         accept;
   rsp_data_type result;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;

   // timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= ACK_TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   i2cra_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .item_accept (accept),
      .item_kind   (req_tuser),
      .item_data   (req_data_type'(req_tdata[24:0])),
      .ack_timeout (timeout_ff),
      .result      (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

endmodule

>>> rtl/i2cra_checker.sv
// i2cra_checker: port-level assertions for the i2c register access master
// bound to i2c_register_access_master_core; depends on nothing else
module i2cra_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // completion is never flagged with the bus still busy
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |-> !rsp_tdata[3])
      else $error("done with busy set");

   // an idle bus has both lines high and driven
   a_idle_lines: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[3] |-> rsp_tdata[0] && rsp_tdata[1] && rsp_tdata[2])
      else $error("idle bus lines not high");

   // released sda reads high, with the bus busy, in the ack and read phases
   a_release: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[2] |-> rsp_tdata[1] && rsp_tdata[3])
      else $error("released sda not high or bus idle");

   // nothing offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind i2c_register_access_master_core i2cra_checker u_i2cra_checker (.*);
